FILE: rtl/fp8sr_pkg.sv
package fp8sr_pkg;

	// Widths of the beat fields and of the internal fixed-point words.
	localparam int VALUE_W = 32;
	localparam int RND_W   = 24;
	localparam int CODE_W  = 8;
	localparam int LEVEL_W = 7;
	localparam int SIG_W   = 24;
	localparam int WIDE_W  = SIG_W + RND_W;
	localparam int SH_W    = $clog2(WIDE_W + 1);
	localparam int FRAC_W  = RND_W + 1;
	localparam int NFRAC_W = 20;

	// Magnitude thresholds on the raw single-precision bits.
	localparam logic [30:0] MAG_SAT  = 31'h43E0_0000;
	localparam logic [30:0] MAG_NORM = 31'h3C80_0000;

	localparam logic [7:0] EXP_SPECIAL      = 8'hFF;
	localparam logic [7:0] EXP_OFS          = 8'd120;
	localparam logic [7:0] SUB_SHIFT_BASE   = 8'd141;
	localparam logic [7:0] SUB_SHIFT_DENORM = 8'd140;

	// Output codes.
	localparam logic [CODE_W-1:0] CODE_MAX_POS = 8'h7E;
	localparam logic [CODE_W-1:0] CODE_MAX_NEG = 8'hFE;
	localparam logic [CODE_W-1:0] CODE_ZERO    = 8'h00;
	localparam logic [LEVEL_W-1:0] LEVEL_TOP   = 7'h7D;

	// Stage 1 result: classified input.
	typedef struct packed {
		logic                neg;
		logic                spec;
		logic [CODE_W-1:0]   spec_code;
		logic                norm;
		logic [LEVEL_W-1:0]  lower_n;
		logic [RND_W-1:0]    frac_n;
		logic [SIG_W-1:0]    sig;
		logic [SH_W-1:0]     sh;
		logic [RND_W-1:0]    rnd;
	} s1_t;

	// Stage 2 result: lower level and discarded fraction, scaled to the random word.
	typedef struct packed {
		logic                neg;
		logic                spec;
		logic [CODE_W-1:0]   spec_code;
		logic [LEVEL_W-1:0]  lower;
		logic [FRAC_W-1:0]   frac;
		logic [RND_W-1:0]    rnd;
	} s2_t;

endpackage

FILE: rtl/fp8_e4m3_stochastic_rounder.sv
// Channel  Dir  Beat fields (lowest bit up)                      Handshake
// s_axis   in   value_bits[31:0], random_bits[55:32]             tvalid / tready
// m_axis   out  fp8_code[7:0]                                    tvalid / tready
//
// A beat passes three register stages: decode, align and round. Its code sits in
// the output register of the round stage, which drives m_axis. A new beat may
// enter every cycle as long as m_axis does not stall.
// Each stage holds its beat while the next is full, so a stall on m_axis
// backs up stage by stage and no beat is lost or repeated.
// Reset clears the valid bits of all three stages; the data registers are not reset.
module fp8_e4m3_stochastic_rounder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // value_bits[31:0], random_bits[55:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // fp8_code[7:0]
);

	// Stage 1 sorts out the special inputs (infinity, NaN, saturation and zero)
	// and prepares the significand and its shift for the subnormal range.
	logic           vld_a;
	logic           rdy_a;
	fp8sr_pkg::s1_t dat_a;

	// Stage 2 produces the lower level and the discarded fraction, scaled so
	// that it compares directly with the random word.
	logic           vld_b;
	logic           rdy_b;
	fp8sr_pkg::s2_t dat_b;

	fp8sr_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.value_bits  (s_axis_tdata[fp8sr_pkg::VALUE_W-1:0]),
		.random_bits (s_axis_tdata[fp8sr_pkg::VALUE_W+fp8sr_pkg::RND_W-1:fp8sr_pkg::VALUE_W]),
		.out_valid   (vld_a),
		.out_ready   (rdy_a),
		.out_data    (dat_a)
	);

	fp8sr_align u_align (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_a),
		.in_ready  (rdy_a),
		.in_data   (dat_a),
		.out_valid (vld_b),
		.out_ready (rdy_b),
		.out_data  (dat_b)
	);

	// Stage 3 makes the exact comparison, adds the step and applies the sign.
	// Its register drives the output beat.
	fp8sr_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_b),
		.in_ready  (rdy_b),
		.in_data   (dat_b),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.code      (m_axis_tdata)
	);

endmodule

FILE: rtl/fp8sr_decode.sv
module fp8sr_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fp8sr_pkg::VALUE_W-1:0]     value_bits,
	input  logic [fp8sr_pkg::RND_W-1:0]       random_bits,
	output logic                              out_valid,
	input  logic                              out_ready,
	output fp8sr_pkg::s1_t                    out_data
);

	logic           vld_s1;
	fp8sr_pkg::s1_t data_s1;
	fp8sr_pkg::s1_t nxt;

	logic [30:0] mag;
	logic [7:0]  e;
	logic [22:0] m;
	logic [7:0]  s;
	logic [7:0]  e_ofs;

	always_comb begin
		mag   = value_bits[30:0];
		e     = mag[30:23];
		m     = mag[22:0];
		e_ofs = e - fp8sr_pkg::EXP_OFS;
		s     = (e == 8'd0) ? fp8sr_pkg::SUB_SHIFT_DENORM : (fp8sr_pkg::SUB_SHIFT_BASE - e);

		nxt.neg       = value_bits[31];
		nxt.rnd       = random_bits;
		nxt.spec      = 1'b1;
		nxt.spec_code = fp8sr_pkg::CODE_ZERO;
		if (e == fp8sr_pkg::EXP_SPECIAL) begin
			// NaN is never negative; infinity keeps its sign.
			nxt.spec_code = (m != 23'd0 || !value_bits[31]) ?
				fp8sr_pkg::CODE_MAX_POS : fp8sr_pkg::CODE_MAX_NEG;
		end else if (mag >= fp8sr_pkg::MAG_SAT) begin
			nxt.spec_code = value_bits[31] ? fp8sr_pkg::CODE_MAX_NEG : fp8sr_pkg::CODE_MAX_POS;
		end else if (mag == 31'd0) begin
			nxt.spec_code = fp8sr_pkg::CODE_ZERO;
		end else begin
			nxt.spec = 1'b0;
		end

		nxt.norm    = (mag >= fp8sr_pkg::MAG_NORM);
		nxt.lower_n = {e_ofs[3:0], m[22:20]};
		nxt.frac_n  = {m[19:0], {(fp8sr_pkg::RND_W - fp8sr_pkg::NFRAC_W){1'b0}}};
		nxt.sig     = {(e != 8'd0), m};
		nxt.sh      = (s >= 8'(fp8sr_pkg::WIDE_W)) ?
			fp8sr_pkg::SH_W'(fp8sr_pkg::WIDE_W) : s[fp8sr_pkg::SH_W-1:0];
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = data_s1;

	a_special_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && value_bits[30:23] == fp8sr_pkg::EXP_SPECIAL)
		|=> (vld_s1 && data_s1.spec))
		else $error("infinity or NaN not flagged as special");

endmodule

FILE: rtl/fp8sr_align.sv
module fp8sr_align (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fp8sr_pkg::s1_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output fp8sr_pkg::s2_t out_data
);

	logic           vld_s2;
	fp8sr_pkg::s2_t data_s2;
	fp8sr_pkg::s2_t nxt;

	logic [fp8sr_pkg::WIDE_W-1:0] wide_in;
	logic [fp8sr_pkg::WIDE_W-1:0] wide;
	logic [fp8sr_pkg::WIDE_W-1:0] lost_mask;
	logic                         sticky;

	always_comb begin
		// The subnormal significand is scaled so that its fraction lines up with
		// the random word; bits pushed off the end are folded in as a ceiling.
		wide_in   = {in_data.sig, {fp8sr_pkg::RND_W{1'b0}}};
		wide      = wide_in >> in_data.sh;
		lost_mask = ~({fp8sr_pkg::WIDE_W{1'b1}} << in_data.sh);
		sticky    = |(wide_in & lost_mask);

		nxt.neg       = in_data.neg;
		nxt.spec      = in_data.spec;
		nxt.spec_code = in_data.spec_code;
		nxt.rnd       = in_data.rnd;
		if (in_data.norm) begin
			nxt.lower = in_data.lower_n;
			nxt.frac  = {1'b0, in_data.frac_n};
		end else begin
			nxt.lower = {4'd0, wide[fp8sr_pkg::RND_W+2:fp8sr_pkg::RND_W]};
			nxt.frac  = {1'b0, wide[fp8sr_pkg::RND_W-1:0]} + fp8sr_pkg::FRAC_W'(sticky);
		end
	end

	assign in_ready = !vld_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = data_s2;

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (data_s2.frac <= {1'b1, {fp8sr_pkg::RND_W{1'b0}}}))
		else $error("scaled fraction out of range");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !data_s2.spec) |-> (data_s2.lower <= fp8sr_pkg::LEVEL_TOP))
		else $error("lower level beyond the top finite candidate");

endmodule

FILE: rtl/fp8sr_round.sv
module fp8sr_round (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  fp8sr_pkg::s2_t                in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fp8sr_pkg::CODE_W-1:0]  code
);

	logic                              vld_s3;
	logic [fp8sr_pkg::CODE_W-1:0]      code_s3;
	logic                              up;
	logic [fp8sr_pkg::LEVEL_W-1:0]     level;
	logic [fp8sr_pkg::CODE_W-1:0]      nxt;

	always_comb begin
		// Round up when random / 2^RND_W lies below the discarded fraction.
		up    = ({1'b0, in_data.rnd} < in_data.frac);
		level = in_data.lower + fp8sr_pkg::LEVEL_W'(up);
		nxt   = in_data.spec ? in_data.spec_code : {in_data.neg, level};
	end

	assign in_ready = !vld_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s3 <= nxt;
		end
	end

	assign out_valid = vld_s3;
	assign code      = code_s3;

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (code_s3[6:0] <= fp8sr_pkg::CODE_MAX_POS[6:0]))
		else $error("result code beyond the saturation code");

endmodule

FILE: tb/fp8sr_checker.sv
`timescale 1ns / 100ps

module fp8sr_checker
	import fp8sr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // value_bits[31:0], random_bits[55:32]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,  // fp8_code[7:0]
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [RND_W-1:0]   rnd;
		logic [CODE_W-1:0]  code;
	} fp8_expect_t;

	fp8_expect_t pending_codes [$];
	fp8_expect_t head;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// E4M3 code with stochastic rounding. The round-up test r/2^24 < frac/2^shift
	// is done exactly as r * 2^shift < frac * 2^24 on wide integers.
	function automatic logic [CODE_W-1:0] e4m3_round(input logic [VALUE_W-1:0] word,
							 input logic [RND_W-1:0] rnd);
		logic              neg;
		logic [30:0]       mag;
		logic [7:0]        expo;
		logic [22:0]       mant;
		logic [23:0]       sig;
		logic [6:0]        level;
		logic [23:0]       frac;
		int unsigned       shift;
		logic              up;
		logic [71:0]       scaled_rnd;
		logic [71:0]       scaled_frac;
		neg  = word[31];
		mag  = word[30:0];
		expo = mag[30:23];
		mant = mag[22:0];
		if (expo == EXP_SPECIAL)
			return (mant != 0 || !neg) ? CODE_MAX_POS : CODE_MAX_NEG;
		if (mag >= MAG_SAT)
			return neg ? CODE_MAX_NEG : CODE_MAX_POS;
		if (mag == 0)
			return CODE_ZERO;
		if (mag >= MAG_NORM) begin
			level = 7'((int'(expo) - 120) * 8 + int'(mant[22:20]));
			frac  = {4'd0, mant[19:0]};
			shift = 20;
		end else begin
			// Below 2^-6 the steps are 2^-9; single-precision subnormals have no hidden bit.
			sig   = (expo == 0) ? {1'b0, mant} : {1'b1, mant};
			shift = (expo == 0) ? 140 : 141 - int'(expo);
			if (shift >= 24) begin
				level = 7'd0;
				frac  = sig;
			end else begin
				level = 7'(sig >> shift);
				frac  = sig & ((24'd1 << shift) - 24'd1);
			end
		end
		if (frac == 0) begin
			up = 1'b0;
		end else if (shift >= 48) begin
			// frac * 2^24 is below 2^48, so only a zero random word can round up.
			up = (rnd == 0);
		end else begin
			scaled_rnd  = 72'(rnd) << shift;
			scaled_frac = 72'(frac) << 24;
			up = scaled_rnd < scaled_frac;
		end
		return {neg, 7'(level + 7'(up))};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// Results are retired before new beats are recorded, so a result can never
	// be matched against a beat that enters on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_codes.size() == 0) begin
					report_mismatch($sformatf("code %02h with no beat outstanding",
						m_axis_tdata));
				end else begin
					head = pending_codes.pop_front();
					if (m_axis_tdata !== head.code)
						report_mismatch($sformatf(
							"value %08h random %06h: code %02h, expected %02h",
							head.value, head.rnd, m_axis_tdata, head.code));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_codes.push_back('{value: s_axis_tdata[31:0],
					rnd: s_axis_tdata[55:32],
					code: e4m3_round(s_axis_tdata[31:0], s_axis_tdata[55:32])});
			pending <= pending_codes.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import fp8sr_pkg::*;

	// Number of random beats after the directed ones, and the cycle budget, which
	// leaves ample room for the slowest correct run.
	localparam int RANDOM_BEATS = 900;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_EVERY  = 300;

	// Receiver behaviour; each mode is held for a random stretch of cycles.
	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_SLOW,
		RX_PERIODIC
	} rx_mode_t;

	// Directed beats, random word in the upper bits and single-precision value below.
	localparam logic [55:0] DIRECTED_BEATS [24] = '{
		{24'h000000, 32'h0000_0000},  // positive zero
		{24'hFFFFFF, 32'h8000_0000},  // negative zero
		{24'h000000, 32'h7F80_0000},  // positive infinity
		{24'hFFFFFF, 32'hFF80_0000},  // negative infinity
		{24'h123456, 32'h7FC0_0000},  // quiet NaN
		{24'h000000, 32'hFFFF_FFFF},  // NaN with the sign bit set still saturates positive
		{24'h000000, 32'h43E0_0000},  // exactly 448 saturates
		{24'hFFFFFF, 32'hC3E0_0000},  // exactly -448 saturates negative
		{24'h000000, 32'h43DF_FFFF},  // just below 448 rounds up to the top code
		{24'hFFFFFF, 32'h43DF_FFFF},  // just below 448 stays on the top candidate
		{24'hFFFFFF, 32'h3C80_0000},  // smallest normal, exactly on a level
		{24'h000000, 32'h3C7F_FFFF},  // largest subnormal step rounds up into the normals
		{24'hFFFFFF, 32'hBC7F_FFFF},  // same magnitude, negative, stays subnormal
		{24'h000000, 32'h0000_0001},  // tiniest single subnormal, zero random rounds up
		{24'h000001, 32'h0000_0001},  // tiniest single subnormal stays at zero
		{24'hFFFFFF, 32'h3F80_0000},  // 1.0 exactly on a level
		{24'h000000, 32'hBFC0_0000},  // -1.5 exactly on a level
		{24'h7FFFFF, 32'h3F88_0000},  // halfway between levels, random just below half
		{24'h800000, 32'h3F88_0000},  // halfway between levels, random exactly half
		{24'h800000, 32'hBF88_0000},  // negative halfway case
		{24'hFFFFFF, 32'h3B00_0000},  // 2^-9, exactly the first subnormal level
		{24'h7FFFFF, 32'h3B40_0000},  // 1.5 * 2^-9 rounds up
		{24'h800000, 32'h3B40_0000},  // 1.5 * 2^-9 stays
		{24'hAAAAAA, 32'h4355_5555}   // ordinary normal value with a mixed pattern
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;  // value_bits[31:0], random_bits[55:32]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;       // fp8_code[7:0]

	int          fail_count;
	int          pending;
	int          cycle_count = 0;

	// Sender pacing: beats go out in bursts; a steady phase sends back to back.
	int          burst_left = 0;
	bit          steady = 1'b0;

	// Receiver stall pattern state.
	rx_mode_t    rx_mode = RX_ALWAYS;
	int          rx_hold = 0;
	int          rx_phase = 0;

	fp8_e4m3_stochastic_rounder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	fp8sr_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The run is abandoned if it has not finished within the budget.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// The receiver switches between being always ready, tossing a coin each cycle,
	// being mostly stalled and following a fixed three-in-four pattern. Every so
	// often it picks a new mode and a new length for it, so stalls land on every
	// stage of the pipeline and there are long stretches without any stall.
	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_hold <= $urandom_range(8, 120);
		end else begin
			rx_hold <= rx_hold - 1;
		end
		rx_phase <= rx_phase + 1;
		case (rx_mode)
			RX_ALWAYS:   m_axis_tready <= 1'b1;
			RX_COIN:     m_axis_tready <= 1'($urandom);
			RX_SLOW:     m_axis_tready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: m_axis_tready <= (rx_phase[1:0] != 2'd3);
			default:     m_axis_tready <= 1'b1;
		endcase
	end

	// Presents one beat and returns once it has been accepted. At the start of a
	// burst the sender may first drop valid for a random gap; inside a burst valid
	// stays high from one beat to the next.
	task automatic send_beat(input logic [31:0] value, input logic [23:0] rnd);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {rnd, value};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Holds the sender off until every outstanding beat has produced its code.
	// The checker registers its count, hence the first wait.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [31:0] value;
		logic [23:0] rnd;
		logic        sign;
		int          kind;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats: zeros, infinities, NaNs, the saturation boundary, the
		// normal/subnormal boundary, exact levels and both sides of halfway.
		steady = 1'b1;
		foreach (DIRECTED_BEATS[i])
			send_beat(DIRECTED_BEATS[i][31:0], DIRECTED_BEATS[i][55:32]);

		// Let the pipeline empty completely before the random phase starts.
		drain_results();

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			// Every few hundred beats the sender waits for the pipeline to empty and
			// then switches between bursty and back-to-back pacing.
			if (n > 0 && n % DRAIN_EVERY == 0) begin
				drain_results();
				steady = ~steady;
				burst_left = 0;
			end
			if (n == 0)
				steady = 1'b0;

			sign = 1'($urandom);
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1: value = $urandom();
				2, 3, 4: value = {sign, 8'($urandom_range(121, 135)), 23'($urandom)};
				// Exponent of 256..511: straddles the saturation point at 448.
				5: value = {sign, 8'd135, 23'($urandom)};
				// Subnormal range, mostly close to 2^-6 where codes are non-zero.
				6, 7: value = {sign,
					8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
						: $urandom_range(100, 120)),
					23'($urandom)};
				// Values that sit exactly on a normal level.
				8: value = {sign, 8'($urandom_range(121, 135)), 3'($urandom), 20'd0};
				default: begin
					case ($urandom_range(0, 3))
						0: value = {sign, 8'hFF, 23'd0};
						1: value = {sign, 8'hFF, 23'($urandom) | 23'd1};
						2: value = {sign, 31'd0};
						default: value = {sign, 8'd0, 23'($urandom)};
					endcase
				end
			endcase

			case ($urandom_range(0, 7))
				0: rnd = 24'h000000;
				1: rnd = 24'hFFFFFF;
				2: rnd = 24'($urandom_range(0, 255));
				default: rnd = 24'($urandom);
			endcase

			send_beat(value, rnd);
		end

		// Wait for the last codes, then keep the clock running to catch any stray result.
		drain_results();
		repeat (10) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/fp8sr_pkg.sv
rtl/fp8sr_decode.sv
rtl/fp8sr_align.sv
rtl/fp8sr_round.sv
rtl/fp8_e4m3_stochastic_rounder.sv
tb/fp8sr_checker.sv
tb/tb.sv
